// ----- src/bsicm_pkg.sv -----
// Shared types, constants and the address decoder of the bank switch / IRQ counter mapper.
// No dependencies; every other file of the block imports this package.
package bsicm_pkg;

  // Slot layout of the bank number file
  localparam int unsigned PrgSlots = 3;
  localparam int unsigned ChrSlots = 8;
  localparam int unsigned NumSlots = PrgSlots + ChrSlots;
  localparam int unsigned SlotW    = 4;
  localparam logic [SlotW-1:0] ChrBase = SlotW'(PrgSlots);
  localparam logic [SlotW-1:0] Prg2Slot = SlotW'(2);

  // Configuration port
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CfgPrgMax = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgChrMax = CfgIdxW'(1);
  localparam logic [7:0] BankMaxReset = 8'hFF;

  // Address pages and exact register addresses
  localparam logic [3:0]  PagePrg01    = 4'h8;
  localparam logic [3:0]  PagePrg2     = 4'h9;
  localparam logic [3:0]  PageChrFirst = 4'hA;
  localparam logic [3:0]  PageChrLast  = 4'hD;
  localparam logic [3:0]  PageReload   = 4'hE;
  localparam logic [15:0] AddrCntLoad  = 16'hF000;
  localparam logic [15:0] AddrCntCtrl  = 16'hF001;
  localparam logic [15:0] AddrMirror   = 16'hF002;

  // Counter width masks
  localparam logic [15:0] Mask4  = 16'h000F;
  localparam logic [15:0] Mask8  = 16'h00FF;
  localparam logic [15:0] Mask12 = 16'h0FFF;
  localparam logic [15:0] Mask16 = 16'hFFFF;

  typedef enum logic [1:0] {
    MirHorz     = 2'd0,
    MirVert     = 2'd1,
    MirSingleLo = 2'd2
  } mirror_e;

  // Input word: one CPU write or one CPU cycle tick
  typedef struct packed {
    logic        func;
    logic [15:0] address;
    logic [7:0]  data;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic             irq;
    logic [1:0]       mirroring;
    logic             bank_written;
    logic [SlotW-1:0] bank_slot;
    logic [7:0]       bank_value;
  } out_word_t;

  // Decoded command handed to the bank file and the counter block
  typedef struct packed {
    logic             tick;
    logic             bank_hit;
    logic             is_chr;
    logic [SlotW-1:0] slot;
    logic             high;
    logic             reload_wr;
    logic [1:0]       nib;
    logic             cnt_load;
    logic             cnt_ctrl;
    logic             mirror_wr;
  } cmd_t;

  // Bank file result
  typedef struct packed {
    logic             written;
    logic [SlotW-1:0] slot;
    logic [7:0]       value;
  } bank_res_t;

  // Counter block status after the current word
  typedef struct packed {
    logic       irq;
    logic [1:0] mirroring;
  } ctrl_status_t;

  function automatic cmd_t decode_item(in_word_t w);
    cmd_t       c;
    logic [3:0] page;
    logic       low_ok;
    logic [3:0] chr_page;
    logic [2:0] chr_idx;
    c        = '0;
    page     = w.address[15:12];
    low_ok   = (w.address[11:2] == 10'd0);
    chr_page = page - PageChrFirst;
    chr_idx  = {chr_page[1:0], w.address[1]};
    c.tick   = w.func;
    c.high   = w.address[0];
    c.nib    = w.address[1:0];
    if (!w.func) begin
      if (page == PagePrg01 && low_ok) begin
        c.bank_hit = 1'b1;
        c.slot     = {{(SlotW-1){1'b0}}, w.address[1]};
      end else if (page == PagePrg2 && w.address[11:1] == 11'd0) begin
        c.bank_hit = 1'b1;
        c.slot     = Prg2Slot;
      end else if ((page inside {[PageChrFirst:PageChrLast]}) && low_ok) begin
        c.bank_hit = 1'b1;
        c.is_chr   = 1'b1;
        c.slot     = ChrBase + {1'b0, chr_idx};
      end else if (page == PageReload && low_ok) begin
        c.reload_wr = 1'b1;
      end else if (w.address == AddrCntLoad) begin
        c.cnt_load = 1'b1;
      end else if (w.address == AddrCntCtrl) begin
        c.cnt_ctrl = 1'b1;
      end else if (w.address == AddrMirror) begin
        c.mirror_wr = 1'b1;
      end
    end
    return c;
  endfunction

endpackage

// ----- src/bsicm_banks.sv -----
// Bank number file: eleven 8-bit slots written a nibble at a time and clamped.
// Depends on bsicm_pkg (cmd_t, bank_res_t, slot layout).
module bsicm_banks (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  bsicm_pkg::cmd_t     cmd_i,
  input  logic [7:0]          data_i,
  input  logic [7:0]          prg_max_i,
  input  logic [7:0]          chr_max_i,
  output bsicm_pkg::bank_res_t res_o
);
  import bsicm_pkg::*;

  logic [7:0] bank_q [NumSlots];
  logic [7:0] old_val;
  logic [7:0] merged;
  logic [7:0] max_val;
  logic [7:0] new_val;

  // Nibble merge and clamp against the slot's maximum
  always_comb begin
    old_val = bank_q[cmd_i.slot];
    merged  = cmd_i.high ? {data_i[3:0], old_val[3:0]} : {old_val[7:4], data_i[3:0]};
    max_val = cmd_i.is_chr ? chr_max_i : prg_max_i;
    new_val = (merged > max_val) ? (merged & max_val) : merged;
  end

  // Result fields read as zero unless a bank was hit
  always_comb begin
    res_o = '0;
    if (cmd_i.bank_hit) begin
      res_o.written = 1'b1;
      res_o.slot    = cmd_i.slot;
      res_o.value   = new_val;
    end
  end

  // Storage: program slots reset to 0, pattern slot n to n
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) begin
        bank_q[i] <= (i < PrgSlots) ? 8'd0 : 8'(i - PrgSlots);
      end
    end else if (fire_i && cmd_i.bank_hit) begin
      bank_q[cmd_i.slot] <= new_val;
    end
  end

endmodule

// ----- src/bsicm_ctrl.sv -----
// IRQ down counter with width mask and one-tick delayed IRQ, plus the mirroring mode.
// Depends on bsicm_pkg (cmd_t, ctrl_status_t, masks, mirror_e).
module bsicm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  bsicm_pkg::cmd_t        cmd_i,
  input  logic [7:0]             data_i,
  output bsicm_pkg::ctrl_status_t status_o
);
  import bsicm_pkg::*;

  logic [15:0] reload_q, reload_d;
  logic [15:0] down_q, down_d;
  logic [15:0] mask_q, mask_d;
  logic        en_q, en_d;
  logic        pend_q, pend_d;
  logic        level_q, level_d;
  mirror_e     mir_q, mir_d;
  logic [15:0] down_dec;

  assign down_dec = down_q - 16'd1;

  // Next state for one word
  always_comb begin
    reload_d = reload_q;
    down_d   = down_q;
    mask_d   = mask_q;
    en_d     = en_q;
    pend_d   = pend_q;
    level_d  = level_q;
    mir_d    = mir_q;
    if (cmd_i.tick) begin
      if (en_q) begin
        if (pend_q) begin
          level_d = 1'b1;
          pend_d  = 1'b0;
        end
        if ((down_q & mask_q) != 16'd0) begin
          down_d = down_dec;
          if ((down_dec & mask_q) == 16'd0) pend_d = 1'b1;
        end
      end
    end else if (cmd_i.reload_wr) begin
      case (cmd_i.nib)
        2'd0:    reload_d[3:0]   = data_i[3:0];
        2'd1:    reload_d[7:4]   = data_i[3:0];
        2'd2:    reload_d[11:8]  = data_i[3:0];
        2'd3:    reload_d[15:12] = data_i[3:0];
        default: reload_d = reload_q;
      endcase
    end else if (cmd_i.cnt_load) begin
      down_d  = reload_q;
      level_d = 1'b0;
    end else if (cmd_i.cnt_ctrl) begin
      en_d = data_i[0];
      if (data_i[3])      mask_d = Mask4;
      else if (data_i[2]) mask_d = Mask8;
      else if (data_i[1]) mask_d = Mask12;
      else                mask_d = Mask16;
      level_d = 1'b0;
    end else if (cmd_i.mirror_wr) begin
      if (data_i[1])      mir_d = MirSingleLo;
      else if (data_i[0]) mir_d = MirVert;
      else                mir_d = MirHorz;
    end
  end

  // Status as it stands after this word
  assign status_o.irq       = level_d;
  assign status_o.mirroring = mir_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= '0;
      down_q   <= '0;
      mask_q   <= Mask16;
      en_q     <= 1'b0;
      pend_q   <= 1'b0;
      level_q  <= 1'b0;
      mir_q    <= MirHorz;
    end else if (fire_i) begin
      reload_q <= reload_d;
      down_q   <= down_d;
      mask_q   <= mask_d;
      en_q     <= en_d;
      pend_q   <= pend_d;
      level_q  <= level_d;
      mir_q    <= mir_d;
    end
  end

endmodule

// ----- src/bank_switch_irq_counter_mapper_top.sv -----
// Top level of the bank switch / IRQ counter mapper.
// Depends on bsicm_pkg, bsicm_banks and bsicm_ctrl.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) takes one word per CPU cycle:
//   either a register write (func 0, address, data) or a cycle tick (func 1).
//   Output channel (out_valid_o / out_stall_i / out_word_o) returns exactly one result
//   word per input word: IRQ level, mirroring mode and, for bank writes, slot and value.
//   Configuration port (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i) sets the
//   program and pattern bank maxima; index 0 and 1, other indexes are dropped. It is
//   always ready; the user writes it only while the block is idle, unchecked by the block.
// Data path and throughput:
//   A word is registered at the input, processed by the decoder, the bank file and the
//   counter, and lands in the result register, where out_valid_o rises; a stalled result
//   can hold the word in the input register before that step.
//   One word per cycle is sustained while out_stall_i is low, set by the read-modify-write
//   of the bank file and counter state.
// Stall and reset:
//   While out_stall_i holds a result, the input register keeps its word and in_stall_o
//   rises only when that register is full. Reset clears all state to its power-up
//   values and both maxima to 255.
module bank_switch_irq_counter_mapper_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  bsicm_pkg::in_word_t              in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output bsicm_pkg::out_word_t             out_word_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bsicm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [7:0]                       cfg_data_i
);
  import bsicm_pkg::*;

  in_word_t     in_q;
  logic         in_valid_q;
  out_word_t    out_q;
  logic         out_valid_q;
  logic [7:0]   prg_max_q;
  logic [7:0]   chr_max_q;
  logic         fire;
  logic         out_free;
  cmd_t         cmd;
  bank_res_t    bank_res;
  ctrl_status_t status;

  // Pipeline control
  assign out_free    = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign cfg_ready_o = 1'b1;

  assign cmd = decode_item(in_q);

  bsicm_banks u_banks (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .cmd_i     (cmd),
    .data_i    (in_q.data),
    .prg_max_i (prg_max_q),
    .chr_max_i (chr_max_q),
    .res_o     (bank_res)
  );

  bsicm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .cmd_i    (cmd),
    .data_i   (in_q.data),
    .status_o (status)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_q <= in_word_i;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.irq          <= status.irq;
      out_q.mirroring    <= status.mirroring;
      out_q.bank_written <= bank_res.written;
      out_q.bank_slot    <= bank_res.slot;
      out_q.bank_value   <= bank_res.value;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_max_q <= BankMaxReset;
      chr_max_q <= BankMaxReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgPrgMax: prg_max_q <= cfg_data_i;
        CfgChrMax: chr_max_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

endmodule

// ----- src/bsicm_checker.sv -----
// Port-level checks of the mapper's result channel, bound to the top level.
// Depends on bsicm_pkg (out_word_t, slot layout).
module bsicm_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input bsicm_pkg::out_word_t out_word_o
);
  import bsicm_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // Non-bank words carry zero slot and value
  a_no_bank_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.bank_written |->
      out_word_o.bank_slot == '0 && out_word_o.bank_value == '0)
    else $error("bank fields set on a non-bank word");

  // Mirroring never shows the unused code
  a_mirror_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.mirroring != 2'd3)
    else $error("illegal mirroring code");

  // Bank slots stay inside the file
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.bank_written |->
      out_word_o.bank_slot < SlotW'(NumSlots))
    else $error("bank slot out of range");

endmodule

bind bank_switch_irq_counter_mapper_top bsicm_checker u_bsicm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

// ----- verif/bank_switch_irq_counter_mapper_top_test.sv -----
// Self-checking testbench of the bank switch / IRQ counter mapper top level.
// Needs bsicm_pkg and bank_switch_irq_counter_mapper_top; the expected words come from
// an in-bench model of the mapper state, checked in order against every result word.
`timescale 1ns / 1ps

module bank_switch_irq_counter_mapper_top_test;
  import bsicm_pkg::*;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncTick  = 1'b1;
  localparam int   PhaseItems = 170;
  localparam int   LongHold   = 120;
  localparam int   IdleLimit  = 3000;
  localparam int   SettleCycles = 6;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;

  bank_switch_irq_counter_mapper_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // CPU words waiting for the driver, and mapper outputs still due from the block
  in_word_t  cpu_word_q[$];
  out_word_t mapper_out_q[$];
  int        words_queued = 0;
  int        err_count = 0;

  // Mapper state as the bench sees it
  logic [7:0]  prg_max, chr_max;
  logic [7:0]  prg_bank[PrgSlots];
  logic [7:0]  chr_bank[ChrSlots];
  logic [15:0] reload_val, cnt_val, cnt_mask;
  logic        cnt_en, irq_pend, irq_lvl;
  mirror_e     mir_mode;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic model_reset();
    prg_max = BankMaxReset;
    chr_max = BankMaxReset;
    for (int i = 0; i < PrgSlots; i++) prg_bank[i] = '0;
    for (int i = 0; i < ChrSlots; i++) chr_bank[i] = 8'(i);
    reload_val = '0;
    cnt_val    = '0;
    cnt_mask   = Mask16;
    cnt_en     = 1'b0;
    irq_pend   = 1'b0;
    irq_lvl    = 1'b0;
    mir_mode   = MirHorz;
  endtask

  function automatic logic [7:0] clamp_bank(input logic [7:0] v, input logic [7:0] max);
    return (v > max) ? (v & max) : v;
  endfunction

  function automatic logic [7:0] merge_nib(input logic [7:0] old, input logic [3:0] n,
                                           input logic high);
    return high ? {n, old[3:0]} : {old[7:4], n};
  endfunction

  // Advance the mapper state by one CPU word and work out its result word
  task automatic mapper_step(input in_word_t w, output out_word_t r);
    logic [3:0]  page;
    logic [11:0] low;
    int          s;
    r    = '0;
    page = w.address[15:12];
    low  = w.address[11:0];
    if (w.func == FuncTick) begin
      if (cnt_en) begin
        if (irq_pend) begin
          irq_lvl  = 1'b1;
          irq_pend = 1'b0;
        end
        if ((cnt_val & cnt_mask) != 0) begin
          cnt_val = cnt_val - 16'd1;
          if ((cnt_val & cnt_mask) == 0) irq_pend = 1'b1;
        end
      end
    end else if ((page == PagePrg01 && low <= 3) || (page == PagePrg2 && low <= 1)) begin
      s = (page == PagePrg01) ? int'(low[1]) : 2;
      prg_bank[s] = clamp_bank(merge_nib(prg_bank[s], w.data[3:0], w.address[0]), prg_max);
      r.bank_written = 1'b1;
      r.bank_slot    = SlotW'(s);
      r.bank_value   = prg_bank[s];
    end else if (page >= PageChrFirst && page <= PageChrLast && low <= 3) begin
      s = int'(page - PageChrFirst) * 2 + int'(low[1]);
      chr_bank[s] = clamp_bank(merge_nib(chr_bank[s], w.data[3:0], w.address[0]), chr_max);
      r.bank_written = 1'b1;
      r.bank_slot    = ChrBase + SlotW'(s);
      r.bank_value   = chr_bank[s];
    end else if (page == PageReload && low <= 3) begin
      reload_val[int'(low[1:0]) * 4 +: 4] = w.data[3:0];
    end else if (w.address == AddrCntLoad) begin
      cnt_val = reload_val;
      irq_lvl = 1'b0;
    end else if (w.address == AddrCntCtrl) begin
      cnt_en   = w.data[0];
      cnt_mask = w.data[3] ? Mask4 : w.data[2] ? Mask8 : w.data[1] ? Mask12 : Mask16;
      irq_lvl  = 1'b0;
    end else if (w.address == AddrMirror) begin
      mir_mode = w.data[1] ? MirSingleLo : w.data[0] ? MirVert : MirHorz;
    end
    r.irq       = irq_lvl;
    r.mirroring = mir_mode;
  endtask

  // ---------------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------------
  task automatic add_word(input logic f, input logic [15:0] a, input logic [7:0] d);
    in_word_t w;
    w.func    = f;
    w.address = a;
    w.data    = d;
    cpu_word_q.push_back(w);
    words_queued++;
  endtask

  function automatic logic [15:0] reg_addr(input logic [3:0] page, input logic [1:0] low);
    return {page, 10'd0, low};
  endfunction

  task automatic add_ticks(input int n);
    for (int i = 0; i < n; i++) add_word(FuncTick, 16'($urandom), 8'($urandom));
  endtask

  // Reload, load and arm the counter, then let it run down
  task automatic gen_irq_sequence();
    logic [15:0] rv;
    logic [7:0]  ctrl;
    rv   = {($urandom_range(0, 1) ? 8'h00 : 8'($urandom)), 8'($urandom_range(0, 24))};
    ctrl = 8'($urandom);
    if ($urandom_range(0, 4) != 0) ctrl[0] = 1'b1;
    for (int n = 0; n < 4; n++)
      if ($urandom_range(0, 4) != 0)
        add_word(FuncWrite, reg_addr(PageReload, 2'(n)), {4'($urandom), rv[n*4 +: 4]});
    if ($urandom_range(0, 1)) begin
      add_word(FuncWrite, AddrCntLoad, 8'($urandom));
      add_word(FuncWrite, AddrCntCtrl, ctrl);
    end else begin
      add_word(FuncWrite, AddrCntCtrl, ctrl);
      add_word(FuncWrite, AddrCntLoad, 8'($urandom));
    end
    add_ticks($urandom_range(4, 30));
    // now and then disturb a running counter
    case ($urandom_range(0, 3))
      0: add_word(FuncWrite, AddrCntLoad, 8'($urandom));
      1: add_word(FuncWrite, AddrCntCtrl, ctrl ^ 8'($urandom_range(0, 15)));
      2: add_word(FuncWrite, AddrMirror, 8'($urandom));
      default: ;
    endcase
    add_ticks($urandom_range(1, 12));
  endtask

  task automatic gen_bank_group();
    logic [3:0] page;
    repeat ($urandom_range(1, 6)) begin
      page = 4'($urandom_range(int'(PagePrg01), int'(PageChrLast)));
      add_word(FuncWrite, reg_addr(page, 2'($urandom)), 8'($urandom));
    end
    if ($urandom_range(0, 2) == 0) add_word(FuncWrite, AddrMirror, 8'($urandom));
  endtask

  // Random words and near misses of the register addresses
  task automatic gen_noise_group();
    logic [15:0] a;
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 1))
        a = 16'($urandom);
      else
        a = {4'($urandom_range(8, 15)), ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00,
             4'($urandom)};
      add_word(1'($urandom), a, 8'($urandom));
    end
  endtask

  task automatic gen_directed();
    add_word(FuncTick, 16'hFFFF, 8'hFF);                 // tick, counter off, fields ignored
    add_word(FuncWrite, reg_addr(PagePrg01, 2'd0), 8'hFF);
    add_word(FuncWrite, reg_addr(PagePrg01, 2'd1), 8'hF5);
    add_word(FuncWrite, reg_addr(PagePrg01, 2'd2), 8'h0A);
    add_word(FuncWrite, reg_addr(PagePrg01, 2'd3), 8'h03);
    add_word(FuncWrite, reg_addr(PagePrg2, 2'd0), 8'h0C);
    add_word(FuncWrite, reg_addr(PagePrg2, 2'd1), 8'hFE);
    add_word(FuncWrite, reg_addr(PagePrg2, 2'd2), 8'hFF);  // RAM enable, ignored
    add_word(FuncWrite, reg_addr(PageChrFirst, 2'd1), 8'hFF);
    add_word(FuncWrite, reg_addr(4'hB, 2'd2), 8'h07);
    add_word(FuncWrite, reg_addr(PageChrLast, 2'd3), 8'h0F);
    // reload 0x0003, 4-bit counter enabled, load
    add_word(FuncWrite, reg_addr(PageReload, 2'd0), 8'h03);
    add_word(FuncWrite, reg_addr(PageReload, 2'd1), 8'hF0);
    add_word(FuncWrite, reg_addr(PageReload, 2'd2), 8'h00);
    add_word(FuncWrite, reg_addr(PageReload, 2'd3), 8'h00);
    add_word(FuncWrite, AddrCntCtrl, 8'h09);
    add_word(FuncWrite, AddrCntLoad, 8'h00);
    add_ticks(3);
    // reload while the IRQ is pending: it still fires on the next tick
    add_word(FuncWrite, AddrCntLoad, 8'h00);
    add_ticks(2);
    add_word(FuncWrite, AddrMirror, 8'h03);
    add_word(FuncWrite, AddrMirror, 8'h01);
    add_word(FuncWrite, AddrMirror, 8'h00);
    add_word(FuncWrite, reg_addr(PagePrg01, 2'd0) | 16'h0004, 8'hFF);  // low bits too high
    add_word(FuncWrite, 16'h0000, 8'h00);
    add_word(FuncWrite, 16'hFFFF, 8'hFF);
  endtask

  // ---------------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------------
  int hold_req = 0;

  task automatic wait_drained();
    while (cpu_word_q.size() != 0 || in_valid_i || mapper_out_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgPrgMax) prg_max = val;
    else if (idx == CfgChrMax) chr_max = val;
  endtask

  task automatic run_phase(input int n, input bit hold, input bit pause_mid);
    int target;
    bit paused;
    target = words_queued + n;
    paused = 1'b0;
    if (hold) hold_req++;
    while (words_queued < target) begin
      if (pause_mid && !paused && words_queued >= target - n / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: gen_irq_sequence();
        6, 7:             gen_bank_group();
        default:          gen_noise_group();
      endcase
    end
    wait_drained();
  endtask

  initial begin
    model_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gen_directed();
    wait_drained();
    cfg_write(CfgPrgMax, 8'h00);
    cfg_write(CfgChrMax, 8'h00);
    cfg_write(CfgIdxW'($urandom_range(2, 255)), 8'($urandom));  // unknown index, dropped
    run_phase(PhaseItems, 1'b0, 1'b0);
    cfg_write(CfgPrgMax, 8'h0F);
    cfg_write(CfgChrMax, 8'hF0);
    run_phase(PhaseItems, 1'b1, 1'b0);
    cfg_write(CfgPrgMax, 8'($urandom));
    cfg_write(CfgChrMax, 8'($urandom));
    run_phase(PhaseItems, 1'b0, 1'b1);
    cfg_write(CfgPrgMax, 8'h80);
    cfg_write(CfgChrMax, 8'h7F);
    run_phase(PhaseItems, 1'b0, 1'b0);
    cfg_write(CfgPrgMax, 8'hFF);
    cfg_write(CfgChrMax, 8'hFF);
    run_phase(PhaseItems, 1'b1, 1'b0);
    repeat (10) @(posedge clk_i);
    if (mapper_out_q.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", mapper_out_q.size()));
    if (err_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------------
  // Driver: bursts of words with random gaps; a stalled word is held
  // ---------------------------------------------------------------------------------
  int        burst_left = 1;
  int        gap_left = 0;
  out_word_t due_word;

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      mapper_step(in_word_i, due_word);
      mapper_out_q.push_back(due_word);
    end
    if (!(in_valid_i && in_stall_o)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (cpu_word_q.size() != 0) begin
        in_word_i  <= cpu_word_q.pop_front();
        in_valid_i <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Receiver: rotating stall patterns, plus a long hold-off on request
  // ---------------------------------------------------------------------------------
  int hold_done = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 50;
  int stall_tick = 0;

  always @(posedge clk_i) begin
    if (hold_req != hold_done) begin
      hold_done = hold_req;
      hold_left = LongHold;
    end
    stall_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= (stall_tick % 3 == 0);
      endcase
      mode_left--;
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 150);
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Monitor: every accepted result word against the oldest due word
  // ---------------------------------------------------------------------------------
  out_word_t want_word;

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (mapper_out_q.size() == 0) begin
        report_mismatch("result word with nothing due");
      end else begin
        want_word = mapper_out_q.pop_front();
        check_field("irq", out_word_o.irq, want_word.irq);
        check_field("mirroring", out_word_o.mirroring, want_word.mirroring);
        check_field("bank_written", out_word_o.bank_written, want_word.bank_written);
        check_field("bank_slot", out_word_o.bank_slot, want_word.bank_slot);
        check_field("bank_value", out_word_o.bank_value, want_word.bank_value);
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule

// ----- bank_switch_irq_counter_mapper_top.f -----
src/bsicm_pkg.sv
src/bsicm_banks.sv
src/bsicm_ctrl.sv
src/bank_switch_irq_counter_mapper_top.sv
src/bsicm_checker.sv
verif/bank_switch_irq_counter_mapper_top_test.sv
